// ----- hdl/msdt_pkg.sv -----
// shared types and constants of the multi-slot deadline timer
`timescale 1ns / 1ps
`default_nettype none

package msdt_pkg;

	localparam int NUM_TIMERS_DEF = 16;
	localparam int TIME_WIDTH_DEF = 32;
	localparam int SLOT_W         = 4;
	localparam int MASK_W         = 16;
	localparam int NOW_W          = 32;
	localparam int TMO_W          = 32;

	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_SET     = 2'd1,
		REQ_RESTART = 2'd2,
		REQ_QUERY   = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_SLOT   = 2'd1,
		ST_NOT_ALLOC = 2'd2
	} status_e_t;

	// command broadcast to every cell
	typedef struct packed {
		logic              valid;
		req_e_t            op;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	// per-cell flags collected by the top level
	typedef struct packed {
		logic alloc_hit;
		logic exp_hit;
		logic expire_now;
	} cell_flags_t;

endpackage

`default_nettype wire

// ----- hdl/msdt_cell.sv -----
// one timer slot: deadline, period and flags, with the allocation chain link
`timescale 1ns / 1ps
`default_nettype none

module msdt_cell #(
	parameter int IDX        = 0,
	parameter int TIME_WIDTH = msdt_pkg::TIME_WIDTH_DEF,
	parameter int IDX_W      = 4
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  msdt_pkg::cmd_t            cmd,
	input  wire  [TIME_WIDTH-1:0]     tick_now,
	input  wire  [TIME_WIDTH-1:0]     tick_next,
	input  wire  [TIME_WIDTH-1:0]     tmo,
	input  wire                       claim_in,
	output logic                      claim_out,
	input  wire  [IDX_W-1:0]          idx_in,
	output logic [IDX_W-1:0]          idx_out,
	output msdt_pkg::cell_flags_t     flags
);

	logic [TIME_WIDTH-1:0] deadline_q;
	logic [TIME_WIDTH-1:0] period_q;
	logic                  alloc_q;
	logic                  pend_q;
	logic                  exp_q;

	logic sel;
	logic take;
	logic restart;
	logic expire_now;

	assign sel = (32'(cmd.slot) == 32'(IDX));

	// a free slot takes the set only when no higher slot is free
	assign take       = cmd.valid && (cmd.op == msdt_pkg::REQ_SET) && !alloc_q && !claim_in;
	assign claim_out  = claim_in | ~alloc_q;
	assign idx_out    = take ? IDX_W'(IDX) : idx_in;
	assign restart    = cmd.valid && (cmd.op == msdt_pkg::REQ_RESTART) && sel && alloc_q;
	assign expire_now = cmd.valid && (cmd.op == msdt_pkg::REQ_TICK) && pend_q
		&& (deadline_q <= tick_next);

	assign flags.alloc_hit  = sel & alloc_q;
	assign flags.exp_hit    = sel & alloc_q & exp_q;
	assign flags.expire_now = expire_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q <= 1'b0;
			pend_q  <= 1'b0;
			exp_q   <= 1'b0;
		end else if (take) begin
			alloc_q <= 1'b1;
			pend_q  <= 1'b1;
			exp_q   <= 1'b0;
		end else if (restart) begin
			pend_q <= 1'b1;
			exp_q  <= 1'b0;
		end else if (expire_now) begin
			pend_q <= 1'b0;
			exp_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			period_q   <= tmo;
			deadline_q <= tick_now + tmo;
		end else if (restart) begin
			deadline_q <= tick_now + period_q;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/multi_slot_deadline_timer.sv -----
// top level of the multi-slot deadline timer: command register, cell row, result register
//
// usage:
//   an item (req_type, timeout, slot) is taken at a rising edge with start high
//   and busy low. req_type selects tick, set, restart or query.
//   each item gives exactly one result on slot_out, status, timed_out,
//   expired_mask and now, shown for one cycle with done high.
// result and busy:
//   the result is registered at the edge after the accepting edge. busy is high
//   for the one cycle in which the command is broadcast to the row of slot cells,
//   so no new item is taken while it is high. that cycle holds the deadline
//   compare in every cell and the free-slot claim that ripples from the
//   highest slot down to slot 0.
// reset:
//   arst_n clears the tick count and every slot's allocated, pending and
//   expired flag; deadlines and periods are written by a set before use.
// flow control:
//   the receiver cannot hold results off; done is a one-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none

module multi_slot_deadline_timer #(
	parameter int NUM_TIMERS = msdt_pkg::NUM_TIMERS_DEF,
	parameter int TIME_WIDTH = msdt_pkg::TIME_WIDTH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  wire  [1:0]                    req_type,
	input  wire  [msdt_pkg::TMO_W-1:0]    timeout,
	input  wire  [msdt_pkg::SLOT_W-1:0]   slot,
	output logic                          done,
	output logic [msdt_pkg::SLOT_W-1:0]   slot_out,
	output logic [1:0]                    status,
	output logic                          timed_out,
	output logic [msdt_pkg::MASK_W-1:0]   expired_mask,
	output logic [msdt_pkg::NOW_W-1:0]    now
);

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	msdt_pkg::cmd_t        cmd_s1;
	logic [TIME_WIDTH-1:0] tmo_s1;
	logic [TIME_WIDTH-1:0] tick_q;
	logic [TIME_WIDTH-1:0] tick_next;
	logic                  accept;

	logic [NUM_TIMERS:0]   claim;
	logic [IDX_W-1:0]      idx [NUM_TIMERS+1];
	msdt_pkg::cell_flags_t flags [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] hit_vec;
	logic [NUM_TIMERS-1:0] exph_vec;
	logic [NUM_TIMERS-1:0] expn_vec;
	logic [msdt_pkg::MASK_W-1:0] mask_w;

	logic                         res_done;
	logic [msdt_pkg::SLOT_W-1:0]  res_slot;
	msdt_pkg::status_e_t          res_status;
	logic                         res_to;
	logic [msdt_pkg::MASK_W-1:0]  res_mask;
	logic [TIME_WIDTH-1:0]        res_now;

	assign busy      = cmd_s1.valid;
	assign accept    = start && !busy;
	assign tick_next = tick_q + TIME_WIDTH'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
			tmo_s1 <= '0;
		end else begin
			cmd_s1.valid <= accept;
			if (accept) begin
				cmd_s1.op   <= msdt_pkg::req_e_t'(req_type);
				cmd_s1.slot <= slot;
				tmo_s1      <= TIME_WIDTH'(timeout);
			end
		end
	end

	// claim and index ripple from the highest slot down to slot 0
	assign claim[NUM_TIMERS] = 1'b0;
	assign idx[NUM_TIMERS]   = '0;

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		msdt_cell #(
			.IDX        (i),
			.TIME_WIDTH (TIME_WIDTH),
			.IDX_W      (IDX_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd_s1),
			.tick_now  (tick_q),
			.tick_next (tick_next),
			.tmo       (tmo_s1),
			.claim_in  (claim[i+1]),
			.claim_out (claim[i]),
			.idx_in    (idx[i+1]),
			.idx_out   (idx[i]),
			.flags     (flags[i])
		);
		assign hit_vec[i]  = flags[i].alloc_hit;
		assign exph_vec[i] = flags[i].exp_hit;
		assign expn_vec[i] = flags[i].expire_now;
	end

	for (genvar b = 0; b < msdt_pkg::MASK_W; b++) begin : g_mask
		if (b < NUM_TIMERS) begin : g_on
			assign mask_w[b] = expn_vec[b];
		end else begin : g_off
			assign mask_w[b] = 1'b0;
		end
	end

	always_comb begin
		res_done   = cmd_s1.valid;
		res_slot   = '0;
		res_status = msdt_pkg::ST_OK;
		res_to     = 1'b0;
		res_mask   = '0;
		res_now    = tick_q;
		unique case (cmd_s1.op)
			msdt_pkg::REQ_TICK: begin
				res_mask = mask_w;
				res_now  = tick_next;
			end
			msdt_pkg::REQ_SET: begin
				if (claim[0]) begin
					res_slot = msdt_pkg::SLOT_W'(idx[0]);
				end else begin
					res_status = msdt_pkg::ST_NO_SLOT;
				end
			end
			msdt_pkg::REQ_RESTART, msdt_pkg::REQ_QUERY: begin
				res_slot = cmd_s1.slot;
				if (!(|hit_vec)) begin
					res_status = msdt_pkg::ST_NOT_ALLOC;
				end else if (cmd_s1.op == msdt_pkg::REQ_QUERY) begin
					res_to = |exph_vec;
				end
			end
			default: begin
				res_done = cmd_s1.valid;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= res_done;
			if (cmd_s1.valid && (cmd_s1.op == msdt_pkg::REQ_TICK)) begin
				tick_q <= tick_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_done) begin
			slot_out     <= res_slot;
			status       <= res_status;
			timed_out    <= res_to;
			expired_mask <= res_mask;
			now          <= msdt_pkg::NOW_W'(res_now);
		end
	end

endmodule

`default_nettype wire

// ----- hdl/msdt_checker.sv -----
// port-level checks for the multi-slot deadline timer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module msdt_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           start,
	input wire                           busy,
	input wire                           done,
	input wire [msdt_pkg::SLOT_W-1:0]    slot_out,
	input wire [1:0]                     status,
	input wire                           timed_out,
	input wire [msdt_pkg::MASK_W-1:0]    expired_mask
);

	// an accepted item raises busy for exactly one cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy ##1 !busy)
		else $error("accepted item did not hold busy for one cycle");

	// every busy cycle is followed by exactly one result strobe
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("result strobe missing after busy");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item in flight");

	// a failed set reports nothing else
	a_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == msdt_pkg::ST_NO_SLOT) |->
			(slot_out == '0) && !timed_out && (expired_mask == '0))
		else $error("no-slot result carries payload");

	// only a tick reports expiries, and a tick has no slot or flag
	a_mask_tick: assert property (@(posedge clk) disable iff (!arst_n)
		done && (expired_mask != '0) |->
			(status == msdt_pkg::ST_OK) && (slot_out == '0) && !timed_out)
		else $error("expiry mask on a non-tick result");

endmodule

bind multi_slot_deadline_timer msdt_checker u_msdt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.slot_out     (slot_out),
	.status       (status),
	.timed_out    (timed_out),
	.expired_mask (expired_mask)
);

`default_nettype wire
